// ===== design/csc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, character codes, class codes and keyword ROM for the C
// source character classifier.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Lookahead window: a byte is classified once this many bytes are visible
  localparam int MAX_KW_LEN   = 9;
  localparam int KW_COUNT     = 32;
  localparam int KW_SLOT_LEN  = 16;
  localparam int WIN_DEPTH    = MAX_KW_LEN;
  localparam int CNT_W        = $clog2(WIN_DEPTH + 1);

  // Request queue between front and back
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);

  // Character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // Result classes
  localparam logic [2:0] CLS_PLAIN = 3'd0;
  localparam logic [2:0] CLS_BLOCK = 3'd1;
  localparam logic [2:0] CLS_STR   = 3'd2;
  localparam logic [2:0] CLS_PREP  = 3'd3;
  localparam logic [2:0] CLS_NUM   = 3'd4;

  // Lexical modes
  localparam logic [1:0] LEX_NORMAL = 2'd0;
  localparam logic [1:0] LEX_BLOCK  = 2'd1;
  localparam logic [1:0] LEX_STRING = 2'd2;

  // Rest-of-line colouring
  localparam logic [1:0] ROL_NONE = 2'd0;
  localparam logic [1:0] ROL_LINE = 2'd1;
  localparam logic [1:0] ROL_PREP = 2'd2;

  // One tagged source byte
  typedef struct packed {
    logic [7:0] code;
    logic       le;
    logic       digit;
    logic       alnum;
    logic       quote;
    logic       bslash;
  } tag_t;

  typedef logic [KW_SLOT_LEN*8-1:0] kw_word_t;

  // Keyword ROM, right-justified strings; empty slots are zero
  function automatic kw_word_t kw_word(input int k);
    kw_word_t w;
    w = '0;
    unique case (k)
      0:  w = "int";
      1:  w = "float";
      2:  w = "char";
      3:  w = "string";
      4:  w = "double";
      5:  w = "class";
      6:  w = "for";
      7:  w = "if";
      8:  w = "while";
      9:  w = "do";
      10: w = "break";
      11: w = "virtual";
      12: w = "this";
      13: w = "else";
      14: w = "delete";
      15: w = "case";
      16: w = "switch";
      17: w = "new";
      18: w = "protected";
      19: w = "private";
      20: w = "public";
      21: w = "bool";
      22: w = "true";
      23: w = "false";
      24: w = "return";
      25: w = "using";
      26: w = "namespace";
      27: w = "throw";
      28: w = "void";
      29: w = "struct";
      30: w = "const";
      31: w = "mutable";
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic int kw_len(input int k);
    kw_word_t w;
    int       n;
    w = kw_word(k);
    n = 0;
    for (int i = 0; i < KW_SLOT_LEN; i++) begin
      if (w[8*i +: 8] != 8'h00) n++;
    end
    return n;
  endfunction

endpackage

// ===== design/csc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_front
// Input side: accepts source bytes and tags each with its character kind
// before it enters the request queue.
// ----------------------------------------------------------------------------
module csc_front
  import csc_pkg::*;
(
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // line_end
  input  logic       q_ready,
  output logic       q_push,
  output tag_t       q_tag
);

  logic [7:0] c;

  assign c         = in_tdata;
  assign in_tready = q_ready;
  assign q_push    = in_tvalid & q_ready;

  always_comb begin
    q_tag.code   = c;
    q_tag.le     = in_tlast;
    q_tag.digit  = (c >= 8'h30) && (c <= 8'h39);
    q_tag.alnum  = ((c >= 8'h30) && (c <= 8'h39)) ||
                   ((c >= 8'h41) && (c <= 8'h5A)) ||
                   ((c >= 8'h61) && (c <= 8'h7A));
    q_tag.quote  = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    q_tag.bslash = (c == CH_BSLASH);
  end

endmodule

// ===== design/csc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_queue
// Small request queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module csc_queue
  import csc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  tag_t push_tag,
  output logic ready,
  output logic valid,
  output tag_t head,
  input  logic pop
);

  tag_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;

  assign ready = (cnt_r != (Q_PTR_W+1)'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tag;
    end
  end

endmodule

// ===== design/csc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_back
// Lookahead window, lexer state, parallel keyword match and result register.
// ----------------------------------------------------------------------------
module csc_back
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  tag_t       q_head,
  output logic       q_pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] char_class, [7:3] zero
  output logic       out_tuser,  // is_keyword
  output logic       out_tlast   // last_of_line
);

  // Window
  tag_t             win_r [WIN_DEPTH];
  tag_t             win_nxt [WIN_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_shift;
  logic             flush_r, flush_nxt;

  // Lexer state
  logic [1:0]       lex_r, lex_nxt;
  logic [1:0]       rol_r, rol_nxt;
  logic [CNT_W-1:0] kwl_r, kwl_nxt;
  logic             hold_r, hold_nxt;
  logic             prev_alnum_r, prev_alnum_nxt;
  logic             prev_bslash_r, prev_bslash_nxt;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       out_cls_r;
  logic             out_kw_r;
  logic             out_last_r;

  logic             out_free, emit, take;
  tag_t             b;
  logic [7:0]       nx;
  logic [2:0]       cls;
  logic             kw;

  // Keyword match
  logic [MAX_KW_LEN-1:0] kw_eq [KW_COUNT];
  logic [KW_COUNT-1:0]   kw_match;
  logic [CNT_W-1:0]      kw_len_k [KW_COUNT];
  logic                  kw_hit;
  logic [CNT_W-1:0]      kw_len_sel;

  for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
    localparam int       L = kw_len(k);
    localparam kw_word_t W = kw_word(k);
    for (genvar j = 0; j < MAX_KW_LEN; j++) begin : g_ch
      if (j < L) begin : g_cmp
        assign kw_eq[k][j] = (win_r[j].code == W[8*(L-1-j) +: 8]);
      end else begin : g_pad
        assign kw_eq[k][j] = 1'b1;
      end
    end
    if ((L >= 1) && (L <= MAX_KW_LEN)) begin : g_ok
      assign kw_len_k[k] = CNT_W'(L);
      assign kw_match[k] = (&kw_eq[k]) && (CNT_W'(L) <= cnt_r);
    end else begin : g_never
      assign kw_len_k[k] = '0;
      assign kw_match[k] = 1'b0;
    end
  end

  // First ROM word in order wins
  always_comb begin
    kw_hit     = 1'b0;
    kw_len_sel = '0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (kw_match[k]) begin
        kw_hit     = 1'b1;
        kw_len_sel = kw_len_k[k];
      end
    end
  end

  // Window control: emit the head when full or when its line has ended
  assign out_free = !out_valid_r || out_tready;
  assign emit     = (cnt_r != '0) &&
                    (flush_r || (cnt_r == CNT_W'(WIN_DEPTH))) && out_free;
  assign take     = q_valid && !flush_r &&
                    ((cnt_r != CNT_W'(WIN_DEPTH)) || emit);
  assign q_pop    = take;

  assign b  = win_r[0];
  assign nx = (cnt_r > CNT_W'(1)) ? win_r[1].code : 8'h00;

  always_comb begin
    cnt_shift = emit ? cnt_r - 1'b1 : cnt_r;
    cnt_nxt   = take ? cnt_shift + 1'b1 : cnt_shift;
    for (int i = 0; i < WIN_DEPTH; i++) begin
      if (emit && (i < WIN_DEPTH - 1)) begin
        win_nxt[i] = win_r[i+1];
      end else begin
        win_nxt[i] = win_r[i];
      end
      if (take && (cnt_shift == CNT_W'(i))) begin
        win_nxt[i] = q_head;
      end
    end
    if (take && q_head.le) begin
      flush_nxt = 1'b1;
    end else if (emit && b.le) begin
      flush_nxt = 1'b0;
    end else begin
      flush_nxt = flush_r;
    end
  end

  // Classify the head byte
  always_comb begin
    cls             = CLS_PLAIN;
    kw              = 1'b0;
    lex_nxt         = lex_r;
    rol_nxt         = rol_r;
    kwl_nxt         = kwl_r;
    hold_nxt        = hold_r;
    prev_alnum_nxt  = b.alnum;
    prev_bslash_nxt = b.bslash;
    priority if (rol_r != ROL_NONE) begin
      cls = (rol_r == ROL_LINE) ? CLS_STR : CLS_PREP;
    end else if (kwl_r != '0) begin
      kw      = 1'b1;
      kwl_nxt = kwl_r - 1'b1;
    end else if (hold_r) begin
      cls      = CLS_BLOCK;
      hold_nxt = 1'b0;
    end else if (lex_r == LEX_BLOCK) begin
      cls = CLS_BLOCK;
      if ((b.code == CH_STAR) && (nx == CH_SLASH)) begin
        lex_nxt  = LEX_NORMAL;
        hold_nxt = 1'b1;
      end
    end else if (lex_r == LEX_STRING) begin
      cls = CLS_STR;
      if (b.quote && !prev_bslash_r) lex_nxt = LEX_NORMAL;
    end else if ((b.code == CH_SLASH) && (nx == CH_SLASH)) begin
      rol_nxt = ROL_LINE;
      cls     = CLS_STR;
    end else if (b.code == CH_HASH) begin
      rol_nxt = ROL_PREP;
      cls     = CLS_PREP;
    end else if (b.digit) begin
      cls = CLS_NUM;
    end else if ((b.code == CH_SLASH) && (nx == CH_STAR)) begin
      lex_nxt  = LEX_BLOCK;
      hold_nxt = 1'b1;
      cls      = CLS_BLOCK;
    end else if (b.quote) begin
      lex_nxt = LEX_STRING;
      cls     = CLS_STR;
    end else begin
      if (!prev_alnum_r && kw_hit) begin
        kw      = 1'b1;
        kwl_nxt = kw_len_sel - 1'b1;
      end
    end
    // Line-scoped state ends with the line
    if (b.le) begin
      rol_nxt         = ROL_NONE;
      kwl_nxt         = '0;
      hold_nxt        = 1'b0;
      prev_alnum_nxt  = 1'b0;
      prev_bslash_nxt = 1'b0;
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      flush_r       <= 1'b0;
      lex_r         <= LEX_NORMAL;
      rol_r         <= ROL_NONE;
      kwl_r         <= '0;
      hold_r        <= 1'b0;
      prev_alnum_r  <= 1'b0;
      prev_bslash_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        lex_r         <= lex_nxt;
        rol_r         <= rol_nxt;
        kwl_r         <= kwl_nxt;
        hold_r        <= hold_nxt;
        prev_alnum_r  <= prev_alnum_nxt;
        prev_bslash_r <= prev_bslash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_r[i] <= win_nxt[i];
    end
    if (emit) begin
      out_cls_r  <= cls;
      out_kw_r   <= kw;
      out_last_r <= b.le;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cls_r};
  assign out_tuser  = out_kw_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== design/c_source_char_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_source_char_classifier
// Colour classifier for C source text, one byte per request.
// ----------------------------------------------------------------------------
// Input channel (in_): one source byte per request in tdata, tlast on the
// last byte of each line. Result channel (out_): one class per byte, in
// order; tdata[2:0] is the class, tuser marks keyword bytes, tlast marks the
// result of a line's last byte.
// A byte is classified once the nine-byte lookahead window holds it and the
// eight bytes after it, or once its line has ended; its result is then
// registered and shown the next cycle. The request that completes the window
// (or the line) passes the queue register and the window register first.
// Within a line the block takes one byte per cycle while the receiver keeps
// up. At a line end the window drains its held bytes, up to nine, one per
// cycle while the receiver keeps up, without taking new ones; the four-entry
// queue behind the front absorbs part of that drain.
// Reset clears the queue, window, lexer mode and result register. When the
// receiver stalls, the result holds, the window stops and the queue fills,
// after which in_tready drops.
// ----------------------------------------------------------------------------
module c_source_char_classifier
  import csc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // line_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] char_class, [7:3] zero
  output logic       out_tuser,  // is_keyword
  output logic       out_tlast   // last_of_line
);

  logic q_ready, q_push, q_valid, q_pop;
  tag_t q_tag, q_head;

  csc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_tag     (q_tag)
  );

  csc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_tag (q_tag),
    .ready    (q_ready),
    .valid    (q_valid),
    .head     (q_head),
    .pop      (q_pop)
  );

  csc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== design/csc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks for the C source character classifier.
// ----------------------------------------------------------------------------
module csc_checker
  import csc_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= CLS_NUM) && (out_tdata[7:3] == 5'b0))
    else $error("result class out of range");

  a_kw_plain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[2:0] == CLS_PLAIN))
    else $error("keyword byte with non-plain class");

  a_handshake_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(in_tready) && !$isunknown(out_tvalid))
    else $error("handshake output unknown");

endmodule

bind c_source_char_classifier csc_checker u_chk (.*);

// ===== sim/tb_c_source_char_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_c_source_char_classifier
// Self-checking bench for the C source character classifier. Source lines
// are streamed in, most of them built from C-like tokens with random
// content, and every returned class is compared in order against a
// lexer-state predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_c_source_char_classifier;
  import csc_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int TARGET_ITEMS = 450;
  localparam int DRAIN_CYCLES = 30;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [2:0] cls;
    logic       kw;
    logic       last;
  } char_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_t;

  class char_class_scoreboard;
    string        keywords [KW_COUNT];
    char_result_t pending_classes[$];
    logic [7:0]   window[$];
    logic [1:0]   lex_mode;
    logic [1:0]   rol_class;
    logic [7:0]   prev_byte;
    int           span_left;
    bit           line_start;
    bit           hold_delim;
    int           errors;
    int           result_idx;

    function new();
      keywords = '{"int", "float", "char", "string", "double", "class", "for", "if",
                   "while", "do", "break", "virtual", "this", "else", "delete", "case",
                   "switch", "new", "protected", "private", "public", "bool", "true",
                   "false", "return", "using", "namespace", "throw", "void", "struct",
                   "const", "mutable"};
      lex_mode   = LEX_NORMAL;
      rol_class  = ROL_NONE;
      prev_byte  = 8'h00;
      span_left  = 0;
      line_start = 1;
      hold_delim = 0;
      errors     = 0;
      result_idx = 0;
    endfunction

    function bit is_alnum(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // Length of the first ROM word that is a prefix of the window, else zero
    function int keyword_at_head();
      int len;
      int j;
      for (int k = 0; k < KW_COUNT; k++) begin
        len = keywords[k].len();
        if (len == 0 || len > window.size() || len > MAX_KW_LEN) continue;
        j = 0;
        while (j < len && window[j] == keywords[k][j]) j++;
        if (j == len) return len;
      end
      return 0;
    endfunction

    function char_result_t classify_head();
      char_result_t r;
      logic [7:0]   b;
      logic [7:0]   nx;
      logic [7:0]   pv;
      int           len;
      b  = window[0];
      nx = (window.size() > 1) ? window[1] : 8'h00;
      pv = line_start ? 8'h00 : prev_byte;
      r  = '{cls: CLS_PLAIN, kw: 1'b0, last: 1'b0};
      if (rol_class != ROL_NONE) begin
        r.cls = (rol_class == ROL_LINE) ? CLS_STR : CLS_PREP;
      end else if (span_left != 0) begin
        r.kw = 1'b1;
        span_left--;
      end else if (hold_delim) begin
        r.cls = CLS_BLOCK;
        hold_delim = 0;
      end else if (lex_mode == LEX_BLOCK) begin
        r.cls = CLS_BLOCK;
        if (b == CH_STAR && nx == CH_SLASH) begin
          lex_mode   = LEX_NORMAL;
          hold_delim = 1;
        end
      end else if (lex_mode == LEX_STRING) begin
        r.cls = CLS_STR;
        if ((b == CH_DQUOTE || b == CH_SQUOTE) && pv != CH_BSLASH) lex_mode = LEX_NORMAL;
      end else if (b == CH_SLASH && nx == CH_SLASH) begin
        rol_class = ROL_LINE;
        r.cls     = CLS_STR;
      end else if (b == CH_HASH) begin
        rol_class = ROL_PREP;
        r.cls     = CLS_PREP;
      end else if (b >= "0" && b <= "9") begin
        r.cls = CLS_NUM;
      end else if (b == CH_SLASH && nx == CH_STAR) begin
        lex_mode   = LEX_BLOCK;
        hold_delim = 1;
        r.cls      = CLS_BLOCK;
      end else if (b == CH_DQUOTE || b == CH_SQUOTE) begin
        lex_mode = LEX_STRING;
        r.cls    = CLS_STR;
      end else if (!is_alnum(pv)) begin
        len = keyword_at_head();
        if (len != 0) begin
          r.kw      = 1'b1;
          span_left = len - 1;
        end
      end
      prev_byte  = b;
      line_start = 0;
      return r;
    endfunction

    function void note_request(logic [7:0] code, logic le);
      char_result_t r;
      window.push_back(code);
      // Emit the head once the window is full, or everything at line end
      while (window.size() > 0 && (le || window.size() >= MAX_KW_LEN)) begin
        r      = classify_head();
        r.last = le && (window.size() == 1);
        pending_classes.push_back(r);
        window.delete(0);
      end
      if (le) begin
        rol_class  = ROL_NONE;
        span_left  = 0;
        hold_delim = 0;
        prev_byte  = 8'h00;
        line_start = 1;
      end
    endfunction

    task report(string what);
      if (errors < PRINT_CAP) $display("[%0t] result %0d: %s", $time, result_idx, what);
      errors++;
    endtask

    task check_result(logic [7:0] tdata, logic tuser, logic tlast);
      char_result_t e;
      if (pending_classes.size() == 0) begin
        report($sformatf("unexpected result tdata=%h tuser=%b tlast=%b", tdata, tuser, tlast));
      end else begin
        e = pending_classes.pop_front();
        if (tdata !== {5'b00000, e.cls})
          report($sformatf("class %h, expected %h", tdata, e.cls));
        if (tuser !== e.kw)
          report($sformatf("keyword flag %b, expected %b", tuser, e.kw));
        if (tlast !== e.last)
          report($sformatf("line end %b, expected %b", tlast, e.last));
      end
      result_idx++;
    endtask

    function int pending();
      return pending_classes.size();
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  char_class_scoreboard sb;
  logic [7:0]           line_buf[$];
  int                   burst_left  = 0;
  bit                   steady      = 0;
  int                   idle_cycles = 0;
  logic [15:0]          rx_cyc      = '0;
  rx_mode_t             rx_mode     = RX_FREE;

  c_source_char_classifier i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver back-pressure; a new random pattern is picked whenever rx_cyc[6:0] is zero
  always @(negedge clk) begin
    rx_cyc <= rx_cyc + 1'b1;
    if (rx_cyc[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_FREE:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_cyc[1:0] == 2'd0);
      default:   out_tready <= (rx_cyc[3:0] < 4'd3);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the handshake
  task automatic send_byte(input logic [7:0] code, input logic le);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= le;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Mostly C-like tokens; one line in ten is raw random bytes
  task automatic build_line();
    int    target;
    int    pick;
    string punct;
    punct  = " ;(){},=*+-";
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
    if ($urandom_range(0, 9) == 0) begin
      repeat (target) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      while (line_buf.size() < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          push_text(sb.keywords[$urandom_range(0, KW_COUNT - 1)]);
        end else if (pick < 40) begin
          repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
              0:       line_buf.push_back(8'h61 + 8'($urandom_range(0, 25)));
              1:       line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
              2:       line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
              default: line_buf.push_back("_");
            endcase
          end
        end else if (pick < 55) begin
          line_buf.push_back(punct[$urandom_range(0, punct.len() - 1)]);
        end else if (pick < 63) begin
          repeat ($urandom_range(1, 4)) line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end else if (pick < 71) begin
          if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_BSLASH);
          line_buf.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
        end else if (pick < 76) begin
          push_text("/*");
        end else if (pick < 81) begin
          push_text("*/");
        end else if (pick < 85) begin
          push_text("//");
        end else if (pick < 88) begin
          line_buf.push_back(CH_HASH);
        end else if (pick < 92) begin
          line_buf.push_back(CH_BSLASH);
        end else if (pick < 96) begin
          line_buf.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
        end else begin
          line_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      while (line_buf.size() > target) line_buf.delete(line_buf.size() - 1);
    end
  endtask

  initial begin
    int sent;
    int lines;
    sb    = new();
    sent  = 0;
    lines = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lines
    push_text("#x");
    send_line();
    // opener star must not close the comment; close on the next line
    push_text("/*/");
    send_line();
    push_text("*/");
    send_line();
    // escaped quote keeps the string open; the quote on the next line closes it
    push_text("\"\\'");
    send_line();
    push_text("'");
    send_line();
    // either quote closes
    push_text("\"x'");
    send_line();
    line_buf.push_back(8'h00);
    push_text("int");
    line_buf.push_back(8'hFF);
    push_text("//q");
    send_line();
    push_text("7");
    send_line();
    // comment opener split across a line end
    push_text("a/");
    send_line();
    push_text("*b");
    send_line();

    while (sent < TARGET_ITEMS) begin
      if (lines % 6 == 0) steady = ($urandom_range(0, 3) == 0);
      build_line();
      sent += line_buf.size();
      lines++;
      send_line();
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/csc_pkg.sv
design/csc_front.sv
design/csc_queue.sv
design/csc_back.sv
design/c_source_char_classifier.sv
design/csc_checker.sv
sim/tb_c_source_char_classifier.sv
